[sv/int_to_decimal_ascii_top_assert.svh]
// Assertion macros for the checker file.
`ifndef INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define I2DA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define I2DA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/i2da_pkg.sv]
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants shared by the decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int REMAIN_W    = $clog2(NUM_DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value_bits;
      logic                   is_unsigned;
   } req_type;

   typedef struct packed {
      logic [7:0]  ascii_char;
      logic        last_char;
      logic [31:0] total_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

endpackage

[sv/i2da_cell.sv]
// ----------------------------------------------------------------------------
// i2da_cell
// One BCD digit of the conversion chain: add-3 and shift, digit shift, clear or hold.
// ----------------------------------------------------------------------------
module i2da_cell (
   input  logic                  clock,
   input  i2da_pkg::cell_op_type op,
   input  logic                  shift_bit,
   input  i2da_pkg::digit_type   shift_digit,
   output logic                  carry_out,
   output i2da_pkg::digit_type   digit_out
);
   import i2da_pkg::*;

   digit_type digit_ff;
   digit_type digit_in;
   digit_type adj;

   // digit >= 5 gets +3 before the doubling shift
   assign adj       = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[3];
   assign digit_out = digit_ff;

   always_comb begin
      unique case (op)
         CELL_HOLD:   digit_in = digit_ff;
         CELL_CLEAR:  digit_in = '0;
         CELL_DABBLE: digit_in = {adj[2:0], shift_bit};
         CELL_SHIFT:  digit_in = shift_digit;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

[sv/int_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// 32-bit binary to decimal ASCII, one character per output word.
// The first character follows the conversion: 32 double-dabble steps, then
//   the chain shifts, dropping leading zeros without an output word.
// A new input word is taken only after the last character of the previous
//   one, as the 10-cell chain shifts every digit out; output stalls hold it.
// Reset: synchronous, clears the control state, output valid and the counter.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2da_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2da_pkg::rsp_type rsp
);
   import i2da_pkg::*;

   // control state
   state_type                state_ff, state_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;   // dabble step
   logic [REMAIN_W-1:0]      remain_ff, remain_in;     // digits left in chain
   logic                     started_ff, started_in;   // first nonzero digit seen
   logic                     neg_ff, neg_in;           // '-' still to send
   logic [31:0]              count_ff, count_in;       // running char count

   // payload
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;           // magnitude, MSB first
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // digit chain, cell 0 is the ones digit
   cell_op_type              cell_op;
   logic      [NUM_DIGITS-1:0] carry;
   digit_type                digit [NUM_DIGITS];
   digit_type                top_digit;

   logic                     slot_free;
   logic                     neg_value;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // output register can take a word this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_digit = digit[NUM_DIGITS-1];
   assign neg_value = !req.is_unsigned && req.value_bits[VALUE_WIDTH-1];

   // In dabble mode each cell feeds its carry to the next higher cell; in
   // shift mode each cell takes the digit of the cell below, and the top
   // cell's digit is the one being printed.
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
         i2da_cell u_cell (
            .clock       (clock),
            .op          (cell_op),
            .shift_bit   (mag_ff[VALUE_WIDTH-1]),
            .shift_digit ('0),
            .carry_out   (carry[i]),
            .digit_out   (digit[i])
         );
      end else begin : g_up
         i2da_cell u_cell (
            .clock       (clock),
            .op          (cell_op),
            .shift_bit   (carry[i-1]),
            .shift_digit (digit[i-1]),
            .carry_out   (carry[i]),
            .digit_out   (digit[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      mag_in       = mag_ff;
      cell_op      = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in     = neg_value ? (~req.value_bits + VALUE_WIDTH'(1))
                                      : req.value_bits;
               neg_in     = neg_value;
               bit_cnt_in = '0;
               cell_op    = CELL_CLEAR;
               state_in   = ST_CONV;
            end
         end

         ST_CONV: begin
            cell_op    = CELL_DABBLE;
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
               remain_in  = REMAIN_W'(NUM_DIGITS);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (neg_ff) begin
               // sign goes out first, chain holds
               if (slot_free) begin
                  neg_in            = 1'b0;
                  count_in          = count_ff + 32'd1;
                  rsp_valid_in      = 1'b1;
                  rsp_in.ascii_char = CHAR_MINUS;
                  rsp_in.last_char  = 1'b0;
                  rsp_in.total_count = count_ff + 32'd1;
               end
            end else if (!started_ff && top_digit == '0 && remain_ff != REMAIN_W'(1)) begin
               // leading zero: drop it without a word
               cell_op   = CELL_SHIFT;
               remain_in = remain_ff - REMAIN_W'(1);
            end else if (slot_free) begin
               cell_op            = CELL_SHIFT;
               remain_in          = remain_ff - REMAIN_W'(1);
               started_in         = 1'b1;
               count_in           = count_ff + 32'd1;
               rsp_valid_in       = 1'b1;
               rsp_in.ascii_char  = CHAR_ZERO + {4'b0000, top_digit};
               rsp_in.last_char   = (remain_ff == REMAIN_W'(1));
               rsp_in.total_count = count_ff + 32'd1;
               if (remain_ff == REMAIN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         remain_ff    <= '0;
         started_ff   <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         remain_ff    <= remain_in;
         started_ff   <= started_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rsp_ff <= rsp_in;
   end

endmodule

[sv/i2da_checker.sv]
// ----------------------------------------------------------------------------
// i2da_checker
// Port-level checks for int_to_decimal_ascii_top, bound to the top level.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_top_assert.svh"

module i2da_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input i2da_pkg::rsp_type rsp
);
   import i2da_pkg::*;

   // stalled word is held
   `I2DA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed under stall")

   // sign is never the closing character
   `I2DA_ASSERT_NOW(a_minus_not_last, rsp_valid && rsp.ascii_char == CHAR_MINUS, !rsp.last_char, "minus marked last")

   // a value still in flight keeps the input closed
   `I2DA_ASSERT_NOW(a_busy_mid_value, rsp_valid && !rsp.last_char, req_stall, "input open mid value")

   // an accepted word closes the input for the conversion
   `I2DA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "input open after accept")

endmodule

bind int_to_decimal_ascii_top i2da_checker u_i2da_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal ASCII converter. A queue of pending
// words feeds a clocked driver; a clocked monitor compares every output
// word, field by field, against characters predicted at input acceptance.
// ----------------------------------------------------------------------------
module testbench;
   import i2da_pkg::*;

   // Run shape
   localparam int RANDOM_WORDS = 350;
   localparam int IDLE_PCT     = 28;      // idle/stall chance per cycle, percent
   localparam int CALM_START   = 8000;    // cycle window with no idling at all
   localparam int CALM_END     = 14000;
   localparam int HOLD_AFTER   = 150;     // output words seen before the long hold
   localparam int HOLD_CYCLES  = 700;     // long output hold-off, in cycles
   localparam int DRAIN_CYCLES = 120;     // settle time after the last character
   localparam int CYCLE_LIMIT  = 400000;  // watchdog limit, in cycles

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   int_to_decimal_ascii_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #1 clock = ~clock;

   // Words waiting to be offered, and characters the block still owes us.
   req_type     pending_words[$];
   rsp_type     owed_chars[$];
   logic [31:0] chars_printed = '0;   // shadow of the block's running count

   int cycle_count   = 0;
   int words_sent    = 0;
   int chars_seen    = 0;
   int errors        = 0;
   int stalled_offers = 0;
   int negatives_sent = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   logic calm;
   assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

   // Work out the characters one word produces: optional minus, then the
   // digits most significant first, leading zeros dropped, a zero as '0'.
   // Most negative signed and largest unsigned need nothing special: the
   // magnitude fits in 32 bits unsigned either way.
   task automatic spell_decimal(input req_type w);
      logic        neg;
      logic [31:0] mag;
      logic [3:0]  digit_buf[10];
      int          ndig;
      rsp_type     c;
      begin
         neg  = !w.is_unsigned && w.value_bits[31];
         mag  = neg ? (~w.value_bits + 32'd1) : w.value_bits;
         ndig = 0;
         do begin
            digit_buf[ndig] = 4'(mag % 32'd10);
            mag  = mag / 32'd10;
            ndig++;
         end while (mag != 0 && ndig < 10);
         if (neg) begin
            chars_printed = chars_printed + 32'd1;
            c.ascii_char  = CHAR_MINUS;
            c.last_char   = 1'b0;
            c.total_count = chars_printed;
            owed_chars.push_back(c);
            negatives_sent++;
         end
         for (int i = ndig - 1; i >= 0; i--) begin
            chars_printed = chars_printed + 32'd1;
            c.ascii_char  = CHAR_ZERO + {4'd0, digit_buf[i]};
            c.last_char   = (i == 0);
            c.total_count = chars_printed;
            owed_chars.push_back(c);
         end
      end
   endtask

   task automatic queue_word(input logic [31:0] v, input logic u);
      req_type w;
      begin
         w.value_bits  = v;
         w.is_unsigned = u;
         pending_words.push_back(w);
      end
   endtask

   // Random value with a spread of digit counts, so short and long strings
   // both show up; some raw 32-bit noise and some tiny values too.
   function automatic logic [31:0] pick_value();
      int          style;
      int          ndig;
      longint      lo;
      longint      hi;
      logic [31:0] v;
      begin
         style = $urandom_range(9);
         if (style < 3) begin
            v = $urandom;
         end else if (style == 3) begin
            v = $urandom_range(20);
         end else begin
            ndig = $urandom_range(10, 1);
            lo   = 1;
            for (int i = 1; i < ndig; i++) lo = lo * 10;
            hi   = (ndig == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
            if (ndig == 1) lo = 0;
            v = $urandom_range(32'(hi), 32'(lo));
         end
         return v;
      end
   endfunction

   // Stimulus: directed corners first, then random words.
   initial begin
      logic [31:0] v;
      logic        u;
      // zero both ways, tiny values, digit count boundaries
      queue_word(32'd0, 1'b0);
      queue_word(32'd0, 1'b1);
      queue_word(32'd1, 1'b0);
      queue_word(32'd9, 1'b1);
      queue_word(32'd10, 1'b0);
      queue_word(32'd99, 1'b1);
      queue_word(32'd100, 1'b0);
      queue_word(32'd999999999, 1'b1);
      queue_word(32'd1000000000, 1'b0);
      // negatives, including minus one and the most negative value
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(-32'sd9, 1'b0);
      queue_word(-32'sd10, 1'b0);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h8000_0001, 1'b0);
      // same bit patterns read unsigned, largest unsigned among them
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b1);
      // alternating bit patterns so every value bit toggles early
      queue_word(32'h5555_5555, 1'b0);
      queue_word(32'hAAAA_AAAA, 1'b0);
      queue_word(32'hAAAA_AAAA, 1'b1);
      queue_word(32'd123456789, 1'b1);
      queue_word(-32'sd123456789, 1'b0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         v = pick_value();
         u = 1'($urandom_range(1));
         // signed reading: flip half of them negative for long minus strings
         if (!u && $urandom_range(1)) v = ~v + 32'd1;
         queue_word(v, u);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, everything owed received, then settle
      while (pending_words.size() > 0 || req_valid) @(posedge clock);
      while (owed_chars.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words (%0d negative), %0d characters checked,",
               words_sent, negatives_sent, chars_seen);
      $display("zero and full-width corners, %0d stalled offers under a %0d-cycle hold",
               stalled_offers, HOLD_CYCLES);
      if (errors == 0 && owed_chars.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d characters still owed", errors, owed_chars.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Driver: predicts at acceptance, keeps a stalled word steady, idles at
   // random except inside the calm window.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            spell_decimal(req);
            words_sent++;
         end
         if (req_valid && req_stall) stalled_offers++;
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req       <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted output word against the oldest owed
   // character and drives the output stall, including one long hold-off
   // that backs the block up into its input.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_seen++;
            if (owed_chars.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: char %h last %b count %0d",
                           rsp.ascii_char, rsp.last_char, rsp.total_count);
            end else begin
               want = owed_chars.pop_front();
               if (rsp.ascii_char !== want.ascii_char || rsp.last_char !== want.last_char ||
                   rsp.total_count !== want.total_count) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at count %0d: want char %h last %b count %0d, got char %h last %b count %0d",
                              want.total_count, want.ascii_char, want.last_char,
                              want.total_count, rsp.ascii_char, rsp.last_char,
                              rsp.total_count);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still owed",
                  cycle_count, owed_chars.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
